FILE: hw/rtl/plateau_lr_reducer_top_assert.svh
// Assertion macros for the port-level checker of the plateau rate reducer.
`ifndef PLATEAU_LR_REDUCER_TOP_ASSERT_SVH
`define PLATEAU_LR_REDUCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet during reset.
`define PRL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet during reset.
`define PRL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/prl_pkg.sv
// Package with widths, register indexes and reset values of the plateau rate reducer.
package prl_pkg;

    localparam int METRIC_W = 32;
    localparam int RATE_W   = 32;
    localparam int FACTOR_W = 16;
    localparam int COUNT_W  = 16;
    localparam int THRESH_W = 31;
    localparam int BAD_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BAD_W-1:0] BAD_COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_MAXIMIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATIENCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHANGE  = 3'd7;

    localparam logic [FACTOR_W-1:0] DECAY_RESET     = 16'd6554;
    localparam logic [COUNT_W-1:0]  PATIENCE_RESET  = 16'd10;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 31'd655;
    localparam logic [RATE_W-1:0]   MIN_CHANGE_RESET = 32'd2;

endpackage

FILE: hw/rtl/plateau_lr_reducer_top.sv
// Top level of the plateau learning-rate reducer: input register, decision logic, result register.
//
// Usage: one beat on the input channel carries an epoch metric (signed Q16.16)
// and the optimizer's current rate (unsigned Q4.28). Each input beat yields
// exactly one result beat with the rate to apply, a reduced flag and an
// improved flag. Both channels use valid and stall; a beat moves on a rising
// edge where valid is high and stall is low.
// A beat lands in the input register; when it moves on, the result register
// is written together with the best metric, the bad-epoch count and the
// cooldown count. The next beat therefore sees them at once, and one beat per
// cycle is sustained while the receiver does not stall. The decision logic
// between the two registers holds one 32x33 signed multiply and compare for
// the threshold test and one 32x16 multiply for the decayed rate.
// When the receiver stalls, the result holds and the input register still
// takes one more beat; in_stall rises only while both registers are full and
// out_stall is high.
// Reset clears all valid flags and state and loads the register defaults.
// Configuration writes take effect at the write edge, meant for idle times.
module plateau_lr_reducer_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [prl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [prl_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [prl_pkg::METRIC_W-1:0]    metric,
    input  logic [prl_pkg::RATE_W-1:0]             current_rate,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [prl_pkg::RATE_W-1:0]             new_rate,
    output logic                                   reduced,
    output logic                                   improved
);

    // Configuration registers
    logic                              maximize_reg;
    logic                              abs_thresh_reg;
    logic [prl_pkg::FACTOR_W-1:0]      decay_reg;
    logic [prl_pkg::COUNT_W-1:0]       patience_reg;
    logic [prl_pkg::THRESH_W-1:0]      threshold_reg;
    logic [prl_pkg::COUNT_W-1:0]       cooldown_cfg_reg;
    logic [prl_pkg::RATE_W-1:0]        rate_floor_reg;
    logic [prl_pkg::RATE_W-1:0]        min_change_reg;

    // Tracking state
    logic signed [prl_pkg::METRIC_W-1:0] best_reg;
    logic                                best_valid_reg;
    logic [prl_pkg::BAD_W-1:0]           bad_count_reg;
    logic [prl_pkg::COUNT_W-1:0]         cooldown_reg;

    // Pipeline registers
    logic                                s1_valid_reg;
    logic signed [prl_pkg::METRIC_W-1:0] s1_metric_reg;
    logic [prl_pkg::RATE_W-1:0]          s1_rate_reg;
    logic                                out_valid_reg;
    logic [prl_pkg::RATE_W-1:0]          new_rate_reg;
    logic                                reduced_reg;
    logic                                improved_reg;

    logic                                out_free;
    logic                                advance;
    logic                                in_take;

    logic signed [32:0]                  thr_s;
    logic signed [32:0]                  scale;
    logic signed [64:0]                  rel_lhs;
    logic signed [64:0]                  rel_rhs;
    logic signed [33:0]                  best_ext;
    logic signed [33:0]                  thr_ext;
    logic signed [33:0]                  metric_ext;
    logic signed [33:0]                  abs_hi;
    logic signed [33:0]                  abs_lo;
    logic                                beats;

    logic [prl_pkg::BAD_W-1:0]           bad_step;
    logic [prl_pkg::BAD_W-1:0]           bad_after;
    logic                                over_patience;
    logic [prl_pkg::RATE_W+prl_pkg::FACTOR_W-1:0] prod;
    logic [prl_pkg::RATE_W-1:0]          decayed;
    logic [prl_pkg::RATE_W-1:0]          cand;
    logic signed [33:0]                  drop;
    logic                                apply_cut;

    logic signed [prl_pkg::METRIC_W-1:0] best_next;
    logic                                best_valid_next;
    logic [prl_pkg::BAD_W-1:0]           bad_count_next;
    logic [prl_pkg::COUNT_W-1:0]         cooldown_next;
    logic [prl_pkg::RATE_W-1:0]          new_rate_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maximize_reg     <= 1'b0;
            abs_thresh_reg   <= 1'b0;
            decay_reg        <= prl_pkg::DECAY_RESET;
            patience_reg     <= prl_pkg::PATIENCE_RESET;
            threshold_reg    <= prl_pkg::THRESHOLD_RESET;
            cooldown_cfg_reg <= '0;
            rate_floor_reg   <= '0;
            min_change_reg   <= prl_pkg::MIN_CHANGE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                prl_pkg::REG_MAXIMIZE:   maximize_reg     <= cfg_data[0];
                prl_pkg::REG_ABS_THRESH: abs_thresh_reg   <= cfg_data[0];
                prl_pkg::REG_DECAY:      decay_reg        <= cfg_data[prl_pkg::FACTOR_W-1:0];
                prl_pkg::REG_PATIENCE:   patience_reg     <= cfg_data[prl_pkg::COUNT_W-1:0];
                prl_pkg::REG_THRESHOLD:  threshold_reg    <= cfg_data[prl_pkg::THRESH_W-1:0];
                prl_pkg::REG_COOLDOWN:   cooldown_cfg_reg <= cfg_data[prl_pkg::COUNT_W-1:0];
                prl_pkg::REG_RATE_FLOOR: rate_floor_reg   <= cfg_data[prl_pkg::RATE_W-1:0];
                prl_pkg::REG_MIN_CHANGE: min_change_reg   <= cfg_data[prl_pkg::RATE_W-1:0];
            endcase
        end
    end

    // Improvement test. Relative mode compares metric * 2^16 with
    // best * (2^16 -/+ threshold) exactly; absolute mode uses best -/+ threshold.
    always_comb
    begin
        thr_s   = signed'({2'b00, threshold_reg});
        scale   = maximize_reg ? (33'sd65536 + thr_s) : (33'sd65536 - thr_s);
        rel_lhs = signed'({{17{s1_metric_reg[31]}}, s1_metric_reg, 16'h0000});
        rel_rhs = best_reg * scale;
        best_ext   = signed'({{2{best_reg[31]}}, best_reg});
        metric_ext = signed'({{2{s1_metric_reg[31]}}, s1_metric_reg});
        thr_ext    = signed'({3'b000, threshold_reg});
        abs_hi     = best_ext + thr_ext;
        abs_lo     = best_ext - thr_ext;
        if (!best_valid_reg)
        begin
            beats = 1'b1;
        end
        else if (abs_thresh_reg)
        begin
            beats = maximize_reg ? (metric_ext > abs_hi) : (metric_ext < abs_lo);
        end
        else
        begin
            beats = maximize_reg ? (rel_lhs > rel_rhs) : (rel_lhs < rel_rhs);
        end
    end

    // Bad-epoch count, cooldown and the rate cut.
    always_comb
    begin
        if (beats)
        begin
            bad_step = '0;
        end
        else if (bad_count_reg != prl_pkg::BAD_COUNT_MAX)
        begin
            bad_step = bad_count_reg + 17'd1;
        end
        else
        begin
            bad_step = bad_count_reg;
        end

        bad_after     = (cooldown_reg != '0) ? '0 : bad_step;
        over_patience = bad_after > {1'b0, patience_reg};

        prod      = s1_rate_reg * decay_reg;
        decayed   = prod[prl_pkg::RATE_W+prl_pkg::FACTOR_W-1:prl_pkg::FACTOR_W];
        cand      = (decayed > rate_floor_reg) ? decayed : rate_floor_reg;
        drop      = signed'({2'b00, s1_rate_reg}) - signed'({2'b00, cand});
        apply_cut = over_patience && (drop > signed'({2'b00, min_change_reg}));

        best_next       = beats ? s1_metric_reg : best_reg;
        best_valid_next = best_valid_reg || beats;
        bad_count_next  = over_patience ? '0 : bad_after;
        if (over_patience)
        begin
            cooldown_next = cooldown_cfg_reg;
        end
        else if (cooldown_reg != '0)
        begin
            cooldown_next = cooldown_reg - 16'd1;
        end
        else
        begin
            cooldown_next = cooldown_reg;
        end
        new_rate_next = apply_cut ? cand : s1_rate_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            bad_count_reg  <= '0;
            cooldown_reg   <= '0;
        end
        else if (advance)
        begin
            best_reg       <= best_next;
            best_valid_reg <= best_valid_next;
            bad_count_reg  <= bad_count_next;
            cooldown_reg   <= cooldown_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_metric_reg <= metric;
            s1_rate_reg   <= current_rate;
        end
        if (advance)
        begin
            new_rate_reg <= new_rate_next;
            reduced_reg  <= apply_cut;
            improved_reg <= beats;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_rate  = new_rate_reg;
    assign reduced   = reduced_reg;
    assign improved  = improved_reg;

endmodule

FILE: hw/rtl/prl_checker.sv
// Port-level checker of the plateau rate reducer and its bind to the top level.
`include "plateau_lr_reducer_top_assert.svh"

module prl_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_stall,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [prl_pkg::RATE_W-1:0]             new_rate,
    input  logic                                   reduced,
    input  logic                                   improved
);

    // A stalled result beat stays put with its payload.
    `PRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(new_rate) && $stable(reduced) && $stable(improved),
        "result beat changed while stalled")

    // The input side only stalls when a full result is held back downstream.
    `PRL_ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without downstream backpressure")

    // An improving epoch clears the bad-epoch count, so it can never cut the rate.
    `PRL_ASSERT_SAME(a_cut_excl, out_valid && reduced, !improved,
        "rate cut on an improving epoch")

endmodule

bind plateau_lr_reducer_top prl_checker u_prl_checker (.*);

FILE: test/plateau_lr_checker.sv
// Scoreboard for the plateau rate reducer: mirrors its registers and state and checks each result beat.
module plateau_lr_checker
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [prl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [prl_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [prl_pkg::METRIC_W-1:0]    metric,
    input  logic [prl_pkg::RATE_W-1:0]             current_rate,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [prl_pkg::RATE_W-1:0]             new_rate,
    input  logic                                   reduced,
    input  logic                                   improved,
    output int                                     fail_count,
    output int                                     pending,
    output int                                     epochs_seen,
    output int                                     cuts_seen,
    output int                                     bests_seen
);

    typedef struct packed {
        logic [prl_pkg::RATE_W-1:0] rate;
        logic                       cut;
        logic                       best;
    } rate_verdict_t;

    rate_verdict_t expected_rates[$];

    // Register copies.
    logic                           want_max;
    logic                           use_abs;
    logic [prl_pkg::FACTOR_W-1:0]   decay;
    logic [prl_pkg::COUNT_W-1:0]    patience;
    logic [prl_pkg::THRESH_W-1:0]   margin;
    logic [prl_pkg::COUNT_W-1:0]    cool_len;
    logic [prl_pkg::RATE_W-1:0]     rate_floor;
    logic [prl_pkg::RATE_W-1:0]     min_drop;

    // Plateau tracking state.
    logic signed [prl_pkg::METRIC_W-1:0] best_seen;
    logic                                best_known;
    logic [prl_pkg::BAD_W-1:0]           stale_epochs;
    logic [prl_pkg::COUNT_W-1:0]         cool_left;

    function automatic rate_verdict_t plateau_step(input logic signed [31:0] m,
                                                   input logic [31:0] rate);
        rate_verdict_t v;
        longint        t;
        longint        b;
        longint        m64;
        longint        lhs;
        longint        rhs;
        longint        rate64;
        longint        prod;
        longint        cand;
        longint        floor64;
        longint        drop64;
        longint        min64;
        logic          better;
        t   = longint'(margin);
        b   = longint'(best_seen);
        m64 = longint'(m);
        if (!best_known)
            better = 1'b1;
        else if (use_abs)
            better = want_max ? (m64 > b + t) : (m64 < b - t);
        else
        begin
            // Exact relative test: metric scaled by one against best scaled by (1 -/+ t).
            lhs    = m64 * 64'sd65536;
            rhs    = want_max ? b * (64'sd65536 + t) : b * (64'sd65536 - t);
            better = want_max ? (lhs > rhs) : (lhs < rhs);
        end
        v.rate = rate;
        v.cut  = 1'b0;
        v.best = better;
        if (better)
        begin
            best_seen    = m;
            best_known   = 1'b1;
            stale_epochs = '0;
        end
        else if (stale_epochs != prl_pkg::BAD_COUNT_MAX)
            stale_epochs = stale_epochs + 1'b1;
        if (cool_left != '0)
        begin
            cool_left    = cool_left - 1'b1;
            stale_epochs = '0;
        end
        if (stale_epochs > patience)
        begin
            rate64  = longint'(rate);
            prod    = (rate64 * longint'(decay)) >> 16;
            floor64 = longint'(rate_floor);
            cand    = (prod > floor64) ? prod : floor64;
            drop64  = rate64 - cand;
            min64   = longint'(min_drop);
            if (drop64 > min64)
            begin
                v.rate = cand[31:0];
                v.cut  = 1'b1;
            end
            cool_left    = cool_len;
            stale_epochs = '0;
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rate_verdict_t want;
        if (!rst_n)
        begin
            want_max     = 1'b0;
            use_abs      = 1'b0;
            decay        = prl_pkg::DECAY_RESET;
            patience     = prl_pkg::PATIENCE_RESET;
            margin       = prl_pkg::THRESHOLD_RESET;
            cool_len     = '0;
            rate_floor   = '0;
            min_drop     = prl_pkg::MIN_CHANGE_RESET;
            best_seen    = '0;
            best_known   = 1'b0;
            stale_epochs = '0;
            cool_left    = '0;
            expected_rates.delete();
            fail_count   = 0;
            pending      = 0;
            epochs_seen  = 0;
            cuts_seen    = 0;
            bests_seen   = 0;
        end
        else
        begin
            // Results are checked ahead of the new input beat of the same edge.
            if (out_valid && !out_stall)
            begin
                if (expected_rates.size() == 0)
                begin
                    $error("new_rate: expected no beat, got %0h", new_rate);
                    fail_count++;
                end
                else
                begin
                    want = expected_rates.pop_front();
                    if (new_rate !== want.rate)
                    begin
                        $error("new_rate: expected %0h, got %0h", want.rate, new_rate);
                        fail_count++;
                    end
                    if (reduced !== want.cut)
                    begin
                        $error("reduced: expected %0b, got %0b", want.cut, reduced);
                        fail_count++;
                    end
                    if (improved !== want.best)
                    begin
                        $error("improved: expected %0b, got %0b", want.best, improved);
                        fail_count++;
                    end
                    cuts_seen  += int'(want.cut);
                    bests_seen += int'(want.best);
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_rates.push_back(plateau_step(metric, current_rate));
                epochs_seen++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    prl_pkg::REG_MAXIMIZE:   want_max   = cfg_data[0];
                    prl_pkg::REG_ABS_THRESH: use_abs    = cfg_data[0];
                    prl_pkg::REG_DECAY:      decay      = cfg_data[prl_pkg::FACTOR_W-1:0];
                    prl_pkg::REG_PATIENCE:   patience   = cfg_data[prl_pkg::COUNT_W-1:0];
                    prl_pkg::REG_THRESHOLD:  margin     = cfg_data[prl_pkg::THRESH_W-1:0];
                    prl_pkg::REG_COOLDOWN:   cool_len   = cfg_data[prl_pkg::COUNT_W-1:0];
                    prl_pkg::REG_RATE_FLOOR: rate_floor = cfg_data;
                    prl_pkg::REG_MIN_CHANGE: min_drop   = cfg_data;
                    default: ;
                endcase
            end
            pending = expected_rates.size();
        end
    end

endmodule

FILE: test/tb_plateau_lr_reducer_top.sv
// Testbench top for the plateau rate reducer: clock, reset, stimulus, watchdog and verdict.
module tb_plateau_lr_reducer_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_EPOCHS   = 160;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   cfg_write = 1'b0;
    logic [prl_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    logic [prl_pkg::CFG_DATA_W-1:0]         cfg_data = '0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic signed [prl_pkg::METRIC_W-1:0]    metric = '0;
    logic [prl_pkg::RATE_W-1:0]             current_rate = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic [prl_pkg::RATE_W-1:0]             new_rate;
    logic                                   reduced;
    logic                                   improved;

    int   fail_count;
    int   pending;
    int   epochs_seen;
    int   cuts_seen;
    int   bests_seen;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;
    logic set_max = 1'b0;

    plateau_lr_reducer_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .metric       (metric),
        .current_rate (current_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_rate     (new_rate),
        .reduced      (reduced),
        .improved     (improved)
    );

    plateau_lr_checker score
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .metric       (metric),
        .current_rate (current_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .new_rate     (new_rate),
        .reduced      (reduced),
        .improved     (improved),
        .fail_count   (fail_count),
        .pending      (pending),
        .epochs_seen  (epochs_seen),
        .cuts_seen    (cuts_seen),
        .bests_seen   (bests_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Ends the run when neither channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [31:0] edge_metric(input int i);
        case (i % 6)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0000;
            4:       return 32'h0000_0001;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] edge_rate(input int i);
        case (i % 5)
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h1000_0000;
            default: return 32'h0000_0005;
        endcase
    endfunction

    task automatic write_reg(input logic [prl_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    // Upper bits beyond each register's width carry junk that the block must drop.
    task automatic load_settings(input logic mx, input logic ab, input logic [15:0] dec,
                                 input logic [15:0] pat, input logic [30:0] thr,
                                 input logic [15:0] cool, input logic [31:0] flr,
                                 input logic [31:0] minc);
        set_max = mx;
        write_reg(prl_pkg::REG_MAXIMIZE,   ($urandom() & 32'hFFFF_FFFE) | {31'd0, mx});
        write_reg(prl_pkg::REG_ABS_THRESH, ($urandom() & 32'hFFFF_FFFE) | {31'd0, ab});
        write_reg(prl_pkg::REG_DECAY,      ($urandom() & 32'hFFFF_0000) | {16'd0, dec});
        write_reg(prl_pkg::REG_PATIENCE,   ($urandom() & 32'hFFFF_0000) | {16'd0, pat});
        write_reg(prl_pkg::REG_THRESHOLD,  ($urandom() & 32'h8000_0000) | {1'b0, thr});
        write_reg(prl_pkg::REG_COOLDOWN,   ($urandom() & 32'hFFFF_0000) | {16'd0, cool});
        write_reg(prl_pkg::REG_RATE_FLOOR, flr);
        write_reg(prl_pkg::REG_MIN_CHANGE, minc);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_epoch(input logic [31:0] m, input logic [31:0] r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        metric       <= m;
        current_rate <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic        mx;
        logic        ab;
        logic [15:0] dec;
        logic [15:0] pat;
        logic [30:0] thr;
        logic [15:0] cool;
        logic [31:0] flr;
        logic [31:0] minc;
        logic [31:0] m;
        logic [31:0] lr;
        longint      walk;
        longint      step;
        int          sel;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults first; the very first metric has no best to beat.
        for (int i = 0; i < 5; i++)
            send_epoch(edge_metric(i), edge_rate(i));

        for (int k = 0; k < 4; k++)
        begin
            settle();
            case (k)
                0: load_settings(1'b0, 1'b0, 16'h8000, 16'd0, 31'd0, 16'd1,
                                 32'h0000_0010, 32'd0);
                1: load_settings(1'b1, 1'b1, 16'h0000, 16'd0, 31'h7FFF_FFFF, 16'd0,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: load_settings(1'b1, 1'b0, 16'hFFFF, 16'd1, 31'h0001_0000, 16'd2,
                                 32'd0, 32'd1);
                default: load_settings(1'b0, 1'b1, 16'h0001, 16'hFFFF, 31'd0, 16'hFFFF,
                                       32'd0, 32'd0);
            endcase
            for (int i = 0; i < 5; i++)
                send_epoch(edge_metric(i + k + 1), edge_rate(i));
        end

        walk = 64'sd0;
        lr   = 32'h0100_0000;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default:
                begin
                    idle_pct  = 21;
                    stall_pct = 21;
                end
            endcase
            mx = 1'($urandom_range(1));
            ab = 1'($urandom_range(1));
            case ($urandom_range(3))
                0:       dec = 16'h0000;
                1:       dec = 16'hFFFF;
                2:       dec = 16'h8000;
                default: dec = 16'($urandom());
            endcase
            pat  = 16'(($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(4));
            cool = 16'($urandom_range(3));
            if (ab)
                thr = 31'(($urandom_range(7) == 0) ? $urandom() : $urandom_range(1 << 17));
            else
            begin
                case ($urandom_range(5))
                    0:       thr = 31'd0;
                    1:       thr = 31'h0001_0000;
                    2:       thr = 31'($urandom());
                    default: thr = 31'($urandom_range(6554));
                endcase
            end
            flr  = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
            minc = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(4);
            load_settings(mx, ab, dec, pat, thr, cool, flr, minc);

            // Mostly a training-like walk: plateaus, gains and setbacks, with some noise.
            for (int n = 0; n < PHASE_EPOCHS; n++)
            begin
                sel  = $urandom_range(99);
                step = longint'($urandom_range(1 << 18, 1));
                if (sel < 45)
                    m = 32'(walk + longint'($urandom_range(32)) - 64'sd16);
                else if (sel < 70)
                begin
                    walk = set_max ? walk + step : walk - step;
                    m    = 32'(walk);
                end
                else if (sel < 82)
                begin
                    walk = set_max ? walk - (step >> 2) : walk + (step >> 2);
                    m    = 32'(walk);
                end
                else if (sel < 96)
                    m = $urandom();
                else
                    m = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                if (walk > 64'sd2147483647 || walk < -64'sd2147483648)
                    walk = 64'sd0;
                case ($urandom_range(9))
                    0:       lr = $urandom();
                    1:       lr = lr >> 1;
                    2:       lr = $urandom_range(16);
                    default: ;
                endcase
                send_epoch(m, lr);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
        $display("Covered %0d epoch beats under 13 register settings and four idle mixes.",
                 epochs_seen);
        $display("Rate cuts checked: %0d, new best metrics checked: %0d.", cuts_seen, bests_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/prl_pkg.sv
hw/rtl/plateau_lr_reducer_top.sv
hw/rtl/prl_checker.sv
test/plateau_lr_checker.sv
test/tb_plateau_lr_reducer_top.sv
